// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers clocked on clk_i and reset by rst_ni.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define FDT_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the following cycle.
`define FDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/fdt_pkg.sv -----
// ---------------------------------------------------------------------------
// fdt_pkg
// Types and constants shared by the factorial divisibility test blocks.
// ---------------------------------------------------------------------------
package fdt_pkg;

  localparam int unsigned PRIME_LIMIT_DEF = 65536;
  localparam int unsigned TABLE_DEPTH     = 6542;
  localparam int unsigned TIDX_W          = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W           = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PRIME_W         = 16;
  localparam int unsigned ARG_W           = 31;
  localparam int unsigned PK_W            = 2 * ARG_W;
  localparam int unsigned SUM_W           = ARG_W + 1;
  localparam int unsigned EXP_W           = 5;
  localparam int unsigned DSTEP_W         = $clog2(ARG_W + 1);

  typedef struct packed {
    logic               en;
    logic [TIDX_W-1:0]  addr;
    logic [PRIME_W-1:0] data;
  } tbl_wr_t;

  typedef struct packed {
    logic             start;
    logic [ARG_W-1:0] dividend;
    logic [ARG_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [ARG_W-1:0] quot;
    logic [ARG_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic valid;
    logic divides;
  } res_t;

  typedef enum logic [2:0] {
    SV_CLEAR,
    SV_READ,
    SV_TEST,
    SV_MARK,
    SV_DONE
  } sieve_state_e;

  typedef enum logic [3:0] {
    C_IDLE,
    C_READ,
    C_LOAD,
    C_CHECK,
    C_DIV,
    C_DIVWAIT,
    C_TAIL,
    C_LSTART,
    C_LCHECK,
    C_LDIV,
    C_LWAIT,
    C_RESULT
  } core_state_e;

endpackage

// ----- rtl/fdt_div.sv -----
// ---------------------------------------------------------------------------
// fdt_div
// Restoring divider producing one quotient bit per cycle.
// ---------------------------------------------------------------------------
module fdt_div import fdt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DSTEP_W-1:0] step_q, step_d;
  logic [ARG_W-1:0]   rem_q, rem_d;
  logic [ARG_W-1:0]   quot_q, quot_d;
  logic [ARG_W-1:0]   dvs_q, dvs_d;
  logic [ARG_W:0]     shifted;
  logic [ARG_W:0]     diff;
  logic               ge;

  assign shifted = {rem_q, quot_q[ARG_W-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    dvs_d  = dvs_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      quot_d = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d  = ge ? diff[ARG_W-1:0] : shifted[ARG_W-1:0];
      quot_d = {quot_q[ARG_W-2:0], ge};
      step_d = step_q + 1'b1;
      if (step_q == DSTEP_W'(ARG_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    dvs_q  <= dvs_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ----- rtl/fdt_sieve.sv -----
// ---------------------------------------------------------------------------
// fdt_sieve
// Clears a composite bitmap after reset and runs the sieve over it,
// streaming each prime found into the prime table, up to TABLE_DEPTH of them.
// ---------------------------------------------------------------------------
module fdt_sieve import fdt_pkg::*; #(
  parameter int unsigned PRIME_LIMIT = PRIME_LIMIT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  output tbl_wr_t          tbl_wr_o,
  output logic [CNT_W-1:0] count_o,
  output logic             done_o
);

  localparam int unsigned MW = $clog2(PRIME_LIMIT + 1);
  localparam logic [MW-1:0] LIMIT = MW'(PRIME_LIMIT);

  logic mark_mem [PRIME_LIMIT + 1];

  sieve_state_e     state_q, state_d;
  logic [MW-1:0]    i_q, i_d;
  logic [MW:0]      j_q, j_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [2*MW-1:0]  sq_q;
  logic             mark_rd_q;
  logic             mark_we;
  logic [MW-1:0]    mark_waddr;
  logic             mark_wdata;
  logic [MW:0]      j_next;

  assign j_next = j_q + {1'b0, i_q};

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      SV_CLEAR: begin
        if (i_q == LIMIT) begin
          i_d     = MW'(2);
          state_d = SV_READ;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      SV_READ: state_d = SV_TEST;
      SV_TEST: begin
        if (!mark_rd_q && cnt_q < CNT_W'(TABLE_DEPTH)) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (!mark_rd_q && sq_q <= (2*MW)'(LIMIT)) begin
          j_d     = sq_q[MW:0];
          state_d = SV_MARK;
        end else if (i_q == LIMIT) begin
          state_d = SV_DONE;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = SV_READ;
        end
      end
      SV_MARK: begin
        j_d = j_next;
        if (j_next > {1'b0, LIMIT}) begin
          if (i_q == LIMIT) begin
            state_d = SV_DONE;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = SV_READ;
          end
        end
      end
      SV_DONE: state_d = SV_DONE;
      default: state_d = SV_CLEAR;
    endcase
  end

  always_comb begin
    mark_we       = 1'b0;
    mark_waddr    = i_q;
    mark_wdata    = 1'b0;
    tbl_wr_o.en   = 1'b0;
    tbl_wr_o.addr = cnt_q[TIDX_W-1:0];
    tbl_wr_o.data = PRIME_W'(i_q);
    unique case (state_q)
      SV_CLEAR: mark_we = 1'b1;
      SV_TEST:  tbl_wr_o.en = !mark_rd_q && cnt_q < CNT_W'(TABLE_DEPTH);
      SV_MARK: begin
        mark_we    = 1'b1;
        mark_waddr = j_q[MW-1:0];
        mark_wdata = 1'b1;
      end
      default: mark_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[mark_waddr] <= mark_wdata;
    end
    mark_rd_q <= mark_mem[i_q];
    sq_q      <= i_q * i_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SV_CLEAR;
      i_q     <= '0;
      j_q     <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      cnt_q   <= cnt_d;
    end
  end

  assign count_o = cnt_q;
  assign done_o  = state_q == SV_DONE;

endmodule

// ----- rtl/fdt_core.sv -----
// ---------------------------------------------------------------------------
// fdt_core
// Holds the prime table and factors each divisor above n by trial division,
// checking every prime exponent against its Legendre sum.
// ---------------------------------------------------------------------------
module fdt_core import fdt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tbl_wr_t          tbl_wr_i,
  input  logic [CNT_W-1:0] tbl_count_i,
  input  logic             tbl_done_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ARG_W-1:0] factorial_arg_i,
  input  logic [ARG_W-1:0] divisor_i,
  output res_t             res_o,
  input  logic             res_ready_i
);

  `include "assert_macros.svh"

  logic [PRIME_W-1:0] tbl_mem [TABLE_DEPTH];
  logic [PRIME_W-1:0] tbl_rd_q;

  core_state_e       state_q, state_d;
  logic [ARG_W-1:0]  n_q, n_d;
  logic [ARG_W-1:0]  rem_q, rem_d;
  logic [ARG_W-1:0]  p_q, p_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [2*PRIME_W-1:0] sq_q, sq_d;
  logic [EXP_W-1:0]  exp_q, exp_d;
  logic              tail_q, tail_d;
  logic [PK_W-1:0]   pk_q, pk_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic              res_q, res_d;
  logic              fits;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  fdt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign fits = SUM_W'(exp_q) <= sum_q;

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    rem_d   = rem_q;
    p_d     = p_q;
    idx_d   = idx_q;
    sq_d    = sq_q;
    exp_d   = exp_q;
    tail_d  = tail_q;
    pk_d    = pk_q;
    sum_d   = sum_q;
    res_d   = res_q;
    unique case (state_q)
      C_IDLE: begin
        if (in_valid_i && tbl_done_i) begin
          n_d = factorial_arg_i;
          priority if (divisor_i == '0) begin
            res_d   = 1'b0;
            state_d = C_RESULT;
          end else if (factorial_arg_i >= divisor_i) begin
            res_d   = 1'b1;
            state_d = C_RESULT;
          end else begin
            rem_d   = divisor_i;
            idx_d   = '0;
            tail_d  = 1'b0;
            state_d = C_READ;
          end
        end
      end
      C_READ: state_d = (idx_q < tbl_count_i) ? C_LOAD : C_TAIL;
      C_LOAD: begin
        p_d     = ARG_W'(tbl_rd_q);
        sq_d    = tbl_rd_q * tbl_rd_q;
        state_d = C_CHECK;
      end
      C_CHECK: begin
        if (SUM_W'(sq_q) > SUM_W'(rem_q)) begin
          state_d = C_TAIL;
        end else begin
          exp_d   = '0;
          state_d = C_DIV;
        end
      end
      C_DIV: state_d = C_DIVWAIT;
      C_DIVWAIT: begin
        if (div_rsp.done) begin
          priority if (div_rsp.rem == '0) begin
            rem_d   = div_rsp.quot;
            exp_d   = exp_q + 1'b1;
            state_d = C_DIV;
          end else if (exp_q != '0) begin
            state_d = C_LSTART;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = C_READ;
          end
        end
      end
      C_TAIL: begin
        if (rem_q > ARG_W'(1)) begin
          p_d     = rem_q;
          exp_d   = EXP_W'(1);
          tail_d  = 1'b1;
          state_d = C_LSTART;
        end else begin
          res_d   = 1'b1;
          state_d = C_RESULT;
        end
      end
      C_LSTART: begin
        if (p_q > n_q) begin
          res_d   = 1'b0;
          state_d = C_RESULT;
        end else begin
          pk_d    = PK_W'(p_q);
          sum_d   = '0;
          state_d = C_LCHECK;
        end
      end
      C_LCHECK: begin
        if (pk_q > PK_W'(n_q)) begin
          if (tail_q || !fits) begin
            res_d   = fits;
            state_d = C_RESULT;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = C_READ;
          end
        end else begin
          state_d = C_LDIV;
        end
      end
      C_LDIV: state_d = C_LWAIT;
      C_LWAIT: begin
        if (div_rsp.done) begin
          sum_d   = sum_q + SUM_W'(div_rsp.quot);
          pk_d    = pk_q[ARG_W-1:0] * p_q;
          state_d = C_LCHECK;
        end
      end
      C_RESULT: begin
        if (res_ready_i) begin
          state_d = C_IDLE;
        end
      end
      default: state_d = C_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o       = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = rem_q;
    div_req.divisor  = p_q;
    res_o.valid      = 1'b0;
    res_o.divides    = res_q;
    unique case (state_q)
      C_IDLE:   in_ready_o = tbl_done_i;
      C_DIV:    div_req.start = 1'b1;
      C_LDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = n_q;
        div_req.divisor  = pk_q[ARG_W-1:0];
      end
      C_RESULT: res_o.valid = 1'b1;
      default:  in_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (tbl_wr_i.en) begin
      tbl_mem[tbl_wr_i.addr] <= tbl_wr_i.data;
    end
    tbl_rd_q <= tbl_mem[idx_q[TIDX_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    rem_q  <= rem_d;
    p_q    <= p_d;
    idx_q  <= idx_d;
    sq_q   <= sq_d;
    exp_q  <= exp_d;
    tail_q <= tail_d;
    pk_q   <= pk_d;
    sum_q  <= sum_d;
    res_q  <= res_d;
  end

  `FDT_ASSERT(a_div_free, div_req.start, !div_rsp.busy, "Divider started while busy.")
  `FDT_ASSERT(a_accept_built, in_valid_i && in_ready_o, tbl_done_i, "Word taken before sieve.")
  `FDT_ASSERT(a_rem_nonzero, state_q == C_CHECK, rem_q != '0, "Cofactor reached zero.")
  `FDT_ASSERT(a_pk_bound, state_q == C_LDIV, pk_q <= PK_W'(n_q), "Prime power above n.")
  `FDT_ASSERT_NEXT(a_result_hold, state_q == C_RESULT && !res_ready_i, state_q == C_RESULT,
                   "Result dropped while stalled.")

endmodule

// ----- rtl/factorial_divisibility_test.sv -----
// ---------------------------------------------------------------------------
// factorial_divisibility_test
// Reports whether a divisor m divides n factorial, using Legendre's formula.
// ---------------------------------------------------------------------------
// After reset the block clears a bitmap of PRIME_LIMIT + 1 entries, one per
// cycle, and then sieves it, reading and testing each number up to
// PRIME_LIMIT and marking the multiples of each prime found; no word is
// accepted until the prime table is complete. Items are processed one at a
// time. A zero divisor or a divisor not above n goes straight to the result
// state, and its result word reaches the output through the core's result
// state and the output register. Otherwise each table prime up to the square
// root of the remaining cofactor costs a trial division, and every division
// runs through one shared 31-step restoring divider; each prime that divides
// m adds one such division per power not above n. The result register lets
// the next word enter while a result waits on the output.
// ---------------------------------------------------------------------------
module factorial_divisibility_test import fdt_pkg::*; #(
  parameter int unsigned PRIME_LIMIT = PRIME_LIMIT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [30:0] factorial_arg, [61:31] divisor
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // [0] divides
);

  tbl_wr_t          tbl_wr;
  logic [CNT_W-1:0] tbl_count;
  logic             tbl_done;
  res_t             res;
  logic             res_ready;
  logic             out_valid_q, out_valid_d;
  logic             out_data_q, out_data_d;

  fdt_sieve #(
    .PRIME_LIMIT (PRIME_LIMIT)
  ) u_sieve (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tbl_wr_o (tbl_wr),
    .count_o  (tbl_count),
    .done_o   (tbl_done)
  );

  fdt_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tbl_wr_i        (tbl_wr),
    .tbl_count_i     (tbl_count),
    .tbl_done_i      (tbl_done),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .factorial_arg_i (s_axis_tdata[ARG_W-1:0]),
    .divisor_i       (s_axis_tdata[2*ARG_W-1:ARG_W]),
    .res_o           (res),
    .res_ready_i     (res_ready)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res.valid && res_ready) begin
      out_valid_d = 1'b1;
      out_data_d  = res.divides;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_data_q};

endmodule

// ----- sim/testbench.sv -----
// ---------------------------------------------------------------------------
// Factorial divisibility testbench
// Streams (n, m) words into the block and checks each answer against a
// Legendre-formula predictor held in a scoreboard, under random idling.
// ---------------------------------------------------------------------------
module testbench;
  import fdt_pkg::*;

  class divides_scoreboard;
    bit   pending_q[$];
    int   mismatches;
    logic [ARG_W-1:0] arg_q[$];
    logic [ARG_W-1:0] div_q[$];

    function bit prime_fits(longint unsigned n, longint unsigned p,
                            longint unsigned cnt);
      longint unsigned total;
      longint unsigned pk;
      if (p > n) return 1'b0;
      total = 0;
      pk = p;
      while (pk <= n) begin
        total += n / pk;
        pk *= p;
      end
      return cnt <= total;
    endfunction

    function bit divides_factorial(logic [ARG_W-1:0] n,
                                   logic [ARG_W-1:0] m);
      longint unsigned rem;
      longint unsigned d;
      longint unsigned cnt;
      bit ok;
      if (m == 0) return 1'b0;
      if (n >= m) return 1'b1;
      rem = m;
      ok = 1'b1;
      d = 2;
      while (ok && d * d <= rem) begin
        cnt = 0;
        while (rem % d == 0) begin
          rem /= d;
          cnt++;
        end
        if (cnt > 0) ok = prime_fits(n, d, cnt);
        d = (d == 2) ? 3 : d + 2;
      end
      if (ok && rem > 1) ok = prime_fits(n, rem, 1);
      return ok;
    endfunction

    function void note_pair(logic [ARG_W-1:0] n, logic [ARG_W-1:0] m);
      pending_q = {pending_q, divides_factorial(n, m)};
      arg_q = {arg_q, n};
      div_q = {div_q, m};
    endfunction

    function void check_word(logic divides);
      bit want;
      logic [ARG_W-1:0] n;
      logic [ARG_W-1:0] m;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word: divides=%0b", divides);
        return;
      end
      want = pending_q.pop_front();
      n = arg_q.pop_front();
      m = div_q.pop_front();
      if (divides !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch n=%0d m=%0d: expected divides=%0b, got %0b", n, m, want, divides);
      end
    endfunction
  endclass

  localparam int unsigned STALL_LIMIT = 1500000;
  localparam int unsigned NUM_RANDOM  = 84;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;

  divides_scoreboard sb;
  bit quiet;
  int unsigned idle_cycles;

  factorial_divisibility_test dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic send_pair(logic [ARG_W-1:0] n, logic [ARG_W-1:0] m);
    @(negedge clk_i);
    while (!quiet && $urandom_range(0, 99) < 12) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {2'b00, m, n};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_pair(n, m);
  endtask

  task automatic send_random_pair();
    logic [ARG_W-1:0] n;
    logic [ARG_W-1:0] m;
    longint unsigned prod;
    int unsigned f;
    case ($urandom_range(0, 9))
      0: begin
        n = ARG_W'($urandom());
        m = '0;
      end
      1: begin
        n = ARG_W'($urandom());
        m = (n == 0) ? '0 : ARG_W'($urandom_range(1, n));
      end
      2, 3, 4, 5: begin
        n = ARG_W'($urandom_range(0, 200));
        m = ARG_W'($urandom_range(1, 100000));
      end
      6, 7, 8: begin
        prod = 1;
        f = $urandom_range(2, 97);
        while (prod * f < 64'h8000_0000) begin
          prod *= f;
          f = $urandom_range(2, 97);
        end
        m = prod[ARG_W-1:0];
        n = ARG_W'($urandom_range(0, 120));
      end
      default: begin
        m = ARG_W'($urandom_range(1, 1 << 20));
        n = ARG_W'($urandom_range(0, m));
      end
    endcase
    send_pair(n, m);
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    quiet = 1'b0;
    sb = new();
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_pair(0, 0);
    send_pair(0, 1);
    send_pair(31'h7fff_ffff, 0);
    send_pair(31'h7fff_ffff, 31'h7fff_ffff);
    send_pair(31'h7fff_ffff, 1);
    send_pair(3, 6);
    send_pair(3, 8);
    send_pair(4, 8);
    send_pair(9, 25);
    send_pair(9, 27);
    send_pair(5, 49);
    send_pair(6, 7);
    send_pair(32, 31'h4000_0000);
    send_pair(31, 31'h4000_0000);
    send_pair(12, 31'h7fff_ffff);
    send_pair(31'h7fff_fffe, 31'h7fff_ffff);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      quiet = (i >= 40 && i < 70);
      send_random_pair();
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    quiet = 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready = quiet || ($urandom_range(0, 99) >= 12);
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      sb.check_word(m_axis_tdata[0]);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial idle_cycles = 0;

endmodule
